FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frequency averager RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define CPFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside of reset.
`define CPFA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/cpfa_pkg.sv
// ----------------------------------------------------------------------------
// cpfa_pkg
// Widths, register indexes, reset values and shared types of the averager.
// ----------------------------------------------------------------------------
package cpfa_pkg;

    localparam int STAMP_W     = 16;
    localparam int FREQ_W      = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int WINDOW_DEF  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TOUCH_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_RATE       = 2'd1;

    // Register reset values
    localparam logic [FREQ_W-1:0] TOUCH_THRESHOLD_RST = 24'd800;
    localparam logic [FREQ_W-1:0] TICK_RATE_RST       = 24'd5000000;

    typedef logic [FREQ_W-1:0]  freq_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    // Request to the serial divider
    typedef struct packed {
        logic  start;
        freq_t dividend;
        freq_t divisor;
    } div_req_t;

    // Command to the window store
    typedef struct packed {
        logic  read;
        logic  load;
        logic  commit;
        freq_t share;
    } win_cmd_t;

endpackage

FILE: rtl/cpfa_if.sv
// ----------------------------------------------------------------------------
// cpfa_if
// Valid/ready channels for capture stamps and averaged results.
// ----------------------------------------------------------------------------
interface cpfa_in_if;
    import cpfa_pkg::*;

    logic   valid;
    logic   ready;
    stamp_t capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);
endinterface

interface cpfa_out_if;
    import cpfa_pkg::*;

    logic  valid;
    logic  ready;
    freq_t average_freq;
    logic  touched;
    logic  sample_taken;

    modport source (output valid, output average_freq, output touched,
                    output sample_taken, input ready);
    modport sink   (input valid, input average_freq, input touched,
                    input sample_taken, output ready);
endinterface

FILE: rtl/cpfa_divider.sv
// ----------------------------------------------------------------------------
// cpfa_divider
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpfa_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  cpfa_pkg::div_req_t  req,
    output cpfa_pkg::freq_t     quotient,
    output logic                done
);
    import cpfa_pkg::*;

    localparam int CNT_W = $clog2(FREQ_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FREQ_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    freq_t            rem_reg, rem_next;
    freq_t            quo_reg, quo_next;
    freq_t            divisor_reg, divisor_next;

    logic [FREQ_W:0]  shifted;
    logic [FREQ_W:0]  trial;

    // Shift one dividend bit into the remainder and try the subtraction
    always_comb
    begin
        shifted      = {rem_reg, quo_reg[FREQ_W-1]};
        trial        = shifted - {1'b0, divisor_reg};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = trial[FREQ_W] ? shifted[FREQ_W-1:0] : trial[FREQ_W-1:0];
            quo_next   = {quo_reg[FREQ_W-2:0], ~trial[FREQ_W]};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `CPFA_NEVER(a_start_while_busy, clk, rst_n, req.start && busy_reg,
        "divider started while a division is running")
    `CPFA_ASSERT(a_done_single, clk, rst_n, done_reg |=> !done_reg,
        "divider done held longer than one cycle")

endmodule

FILE: rtl/cpfa_window.sv
// ----------------------------------------------------------------------------
// cpfa_window
// Sliding window of frequency shares with its running sum.
// ----------------------------------------------------------------------------
module cpfa_window #(
    parameter int WINDOW = cpfa_pkg::WINDOW_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cpfa_pkg::win_cmd_t cmd,
    output cpfa_pkg::freq_t    sum
);
    import cpfa_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    freq_t             store_reg [WINDOW];
    logic [WINDOW-1:0] valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    freq_t             sum_reg;
    freq_t             rd_data_reg;
    logic              rd_valid_reg;
    freq_t             share_reg;
    freq_t             diff_reg;
    freq_t             old_share;

    // Entries never written read as zero
    assign old_share = rd_valid_reg ? rd_data_reg : '0;

    // Read the slot about to be overwritten, then write the new share
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg  <= store_reg[slot_reg];
            rd_valid_reg <= valid_reg[slot_reg];
        end
        if (cmd.load)
        begin
            share_reg <= cmd.share;
            diff_reg  <= cmd.share - old_share;
        end
        if (cmd.commit)
        begin
            store_reg[slot_reg] <= share_reg;
        end
    end

    // Hold valid bits, slot pointer and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg[slot_reg] <= 1'b1;
            sum_reg             <= sum_reg + diff_reg;
            slot_reg            <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
        end
    end

    assign sum = sum_reg;

endmodule

FILE: rtl/captouch_period_freq_average_unit.sv
// ----------------------------------------------------------------------------
// captouch_period_freq_average_unit
// Capture-period to frequency converter with a sliding-window average.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries timer capture stamps; captures alternate between a start
//   stamp and an end stamp. out_ch returns one result per capture: the window
//   average, the touched flag and whether a sample entered the window.
//   The user writes registers via cfg_we / cfg_index / cfg_data while idle.
// Sequence:
//   A start capture or a discarded period goes straight to the result step;
//   a valid period runs the bit-serial divider twice (tick_rate / period,
//   then frequency / WINDOW), then a window update and the result write. One
//   capture is in work at a time. The block does not enforce the idle rule.
// Reset:
//   Registers return to their defaults, the window reads as all zero through
//   per-entry valid bits, and the unit expects a start capture.
// Stall:
//   A result waits in the output register while out_ch is not ready; the
//   next capture is taken meanwhile and holds in its last step until the
//   output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module captouch_period_freq_average_unit #(
    parameter int WINDOW = cpfa_pkg::WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cpfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cpfa_pkg::FREQ_W-1:0]       cfg_data,
    cpfa_in_if.sink                           in_ch,
    cpfa_out_if.source                        out_ch
);
    import cpfa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_DIV2   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t   state_reg, state_next;
    logic     phase_reg, phase_next;
    stamp_t   start_reg, start_next;
    logic     taken_reg, taken_next;
    freq_t    threshold_reg;
    freq_t    tick_rate_reg;
    logic     out_valid_reg, out_valid_next;
    freq_t    out_avg_reg;
    logic     out_touched_reg;
    logic     out_taken_reg;
    logic     out_load;

    logic     accept;
    stamp_t   period;
    div_req_t div_req;
    freq_t    div_quotient;
    logic     div_done;
    win_cmd_t win_cmd;
    freq_t    win_sum;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign period      = in_ch.capture_time - start_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= TOUCH_THRESHOLD_RST;
            tick_rate_reg <= TICK_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOUCH_THRESHOLD: threshold_reg <= cfg_data;
                CFG_TICK_RATE:       tick_rate_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Sequence one capture through divide, update and result
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        start_next  = start_reg;
        taken_next  = taken_reg;
        out_load    = 1'b0;
        div_req     = '{start: 1'b0, dividend: tick_rate_reg,
                        divisor: FREQ_W'(period)};
        win_cmd     = '{read: 1'b0, load: 1'b0, commit: 1'b0, share: div_quotient};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    start_next = in_ch.capture_time;
                    taken_next = 1'b0;
                    state_next = S_DONE;
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (in_ch.capture_time > start_reg)
                        begin
                            div_req.start = 1'b1;
                            win_cmd.read  = 1'b1;
                            taken_next    = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = div_quotient;
                    div_req.divisor  = FREQ_W'(WINDOW);
                    state_next       = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    win_cmd.load = 1'b1;
                    state_next   = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                win_cmd.commit = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drop the result once taken, load a new one when free
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            start_reg     <= '0;
            taken_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_avg_reg     <= win_sum;
            out_touched_reg <= (win_sum < threshold_reg);
            out_taken_reg   <= taken_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.average_freq = out_avg_reg;
    assign out_ch.touched      = out_touched_reg;
    assign out_ch.sample_taken = out_taken_reg;

    cpfa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .quotient (div_quotient),
        .done     (div_done)
    );

    cpfa_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (win_cmd),
        .sum   (win_sum)
    );

    `CPFA_ASSERT(a_accept_leaves_idle, clk, rst_n, accept |=> state_reg != S_IDLE,
        "request accepted but sequencer stayed idle")
    `CPFA_ASSERT(a_done_in_divide, clk, rst_n,
        div_done |-> (state_reg == S_DIV || state_reg == S_DIV2),
        "divider finished outside a divide step")
    `CPFA_ASSERT(a_commit_after_load, clk, rst_n,
        win_cmd.commit |-> $past(win_cmd.load),
        "window commit without a preceding load")

endmodule
